// ===== rtl/bode_pkg.sv =====
// Shared types and constants for the byte-offset delta encoder.
package bode_pkg;

    localparam logic [7:0] ESCAPE_BYTE = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam int unsigned BYTE_IDX_W = 3;

    typedef enum logic [1:0]
    {
        LEN_ONE,
        LEN_THREE,
        LEN_SEVEN
    } code_len_t;

    typedef struct packed
    {
        logic [31:0] delta;
        code_len_t   len;
    } code_entry_t;

endpackage

// ===== rtl/bode_front.sv =====
// Front end: takes samples, forms the wrapped difference and picks the code length.
module bode_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   sample,
    input  logic                 end_of_image,
    input  logic                 queue_full,
    output logic                 push,
    output bode_pkg::code_entry_t push_entry
);
    import bode_pkg::*;

    logic [31:0] prev_reg;
    logic [31:0] prev_next;
    logic [31:0] delta;
    logic        fits8;
    logic        fits16;

    always_comb
    begin
        delta = $unsigned(sample) - prev_reg;
        fits8 = (delta[31:7] == '0) || (delta[31:7] == '1);
        fits16 = (delta[31:15] == '0) || (delta[31:15] == '1);
        push_entry.delta = delta;
        if (fits8 && (delta[7:0] != ESCAPE_BYTE))
        begin
            push_entry.len = LEN_ONE;
        end
        else if (fits16 && (delta[15:0] != {ESCAPE_BYTE, ZERO_BYTE}))
        begin
            push_entry.len = LEN_THREE;
        end
        else
        begin
            push_entry.len = LEN_SEVEN;
        end
        in_stall = queue_full;
        push = in_valid && !queue_full;
        prev_next = end_of_image ? '0 : $unsigned(sample);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (push)
        begin
            prev_reg <= prev_next;
        end
    end

endmodule

// ===== rtl/bode_queue.sv =====
// Short queue of classified differences between the front and back ends.
module bode_queue #(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bode_pkg::code_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output bode_pkg::code_entry_t head_entry
);
    import bode_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    code_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        full = (count_reg == FULL_CNT);
        not_empty = (count_reg != '0);
        head_entry = mem_reg[rd_ptr_reg];
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/bode_back.sv =====
// Back end: serializes each queued difference into code bytes through an output register.
module bode_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  not_empty,
    input  bode_pkg::code_entry_t head_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            code_byte,
    output logic                  last_byte
);
    import bode_pkg::*;

    logic [BYTE_IDX_W-1:0] idx_reg;
    logic                  valid_reg;
    logic [7:0]            byte_reg;
    logic                  last_reg;
    logic [7:0]            byte_next;
    logic                  last_next;
    logic                  advance;
    logic [31:0]           d;

    always_comb
    begin
        d = head_entry.delta;
        byte_next = ESCAPE_BYTE;
        last_next = 1'b1;
        case (head_entry.len)
            LEN_ONE:
            begin
                byte_next = d[7:0];
                last_next = 1'b1;
            end
            LEN_THREE:
            begin
                case (idx_reg)
                    3'd0:    byte_next = ESCAPE_BYTE;
                    3'd1:    byte_next = d[7:0];
                    default: byte_next = d[15:8];
                endcase
                last_next = (idx_reg == 3'd2);
            end
            LEN_SEVEN:
            begin
                case (idx_reg)
                    3'd0:    byte_next = ESCAPE_BYTE;
                    3'd1:    byte_next = ZERO_BYTE;
                    3'd2:    byte_next = ESCAPE_BYTE;
                    3'd3:    byte_next = d[7:0];
                    3'd4:    byte_next = d[15:8];
                    3'd5:    byte_next = d[23:16];
                    default: byte_next = d[31:24];
                endcase
                last_next = (idx_reg == 3'd6);
            end
            default:
            begin
                byte_next = ESCAPE_BYTE;
                last_next = 1'b1;
            end
        endcase
        advance = not_empty && (!valid_reg || !out_stall);
        pop = advance && last_next;
        out_valid = valid_reg;
        code_byte = byte_reg;
        last_byte = last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= byte_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
            idx_reg <= last_next ? '0 : idx_reg + 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/byte_offset_delta_encoder.sv =====
// Byte-offset delta encoder top level: front end, difference queue and byte serializer.
// Each sample becomes one code byte for a difference within +/-127, three
// bytes for one within +/-32767 and seven otherwise. The back end puts out
// one byte per cycle while out_stall is low, so small differences then
// stream at one sample per cycle, and the queue of QUEUE_DEPTH entries lets
// the front end keep taking samples while an escaped code is being serialized.
module byte_offset_delta_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] sample,
    input  logic               end_of_image,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         code_byte,
    output logic               last_byte
);
    import bode_pkg::*;

    code_entry_t push_entry;
    code_entry_t head_entry;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        not_empty;

    bode_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .end_of_image (end_of_image),
        .queue_full   (queue_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    bode_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head_entry (head_entry)
    );

    bode_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (not_empty),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_byte  (code_byte),
        .last_byte  (last_byte)
    );

endmodule

// ===== rtl/bode_checker.sv =====
// Port-level checker for the byte-offset delta encoder and its bind to the top level.
module bode_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  code_byte,
    input logic        last_byte
);
    import bode_pkg::*;

    logic       in_xfer;
    logic       out_xfer;
    logic [7:0] pending_reg;
    logic [2:0] pos_reg;

    assign in_xfer = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {7'd0, in_xfer} - {7'd0, out_xfer && last_byte};
            if (out_xfer)
            begin
                pos_reg <= last_byte ? '0 : pos_reg + 1'b1;
            end
        end
    end

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_byte) && $stable(last_byte))
        else $error("stalled output changed");

    // The last byte of a code only follows an accepted sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && last_byte |-> pending_reg != '0)
        else $error("code completed without a sample");

    // No code is longer than seven bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && (pos_reg == 3'd6) |-> last_byte)
        else $error("code longer than seven bytes");

    // A code of more than one byte opens with the escape byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && (pos_reg == 3'd0) && !last_byte |-> code_byte == ESCAPE_BYTE)
        else $error("multi-byte code without escape");

endmodule

bind byte_offset_delta_encoder bode_checker u_bode_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_byte (code_byte),
    .last_byte (last_byte)
);
